// ===== sv/longest_window_within_band_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the longest_window_within_band block
// Shorthand for concurrent checks clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_WINDOW_WITHIN_BAND_MACROS_SVH
`define LONGEST_WINDOW_WITHIN_BAND_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define LWB_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define LWB_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LWB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lwb_pkg.sv =====
// ----------------------------------------------------------------------------
// lwb_pkg
// Shared widths and the command and status bundles of the window search.
// ----------------------------------------------------------------------------
package lwb_pkg;

	localparam int IN_DATA_W      = 32;
	localparam int SAMPLE_FIELD_W = 32;
	localparam int BAND_W         = 32;
	localparam int LEN_W          = 11;
	localparam int OUT_DATA_W     = 24;

	typedef struct packed {
		logic clr;
		logic sel_head;
		logic pop;
		logic push;
		logic adv;
	} dq_cmd_t;

	typedef struct packed {
		logic take;
		logic pop_max;
		logic pop_min;
		logic sel_head;
		logic push;
		logic adv_max;
		logic adv_min;
		logic step_ws;
		logic set_ovf;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic pop_max;
		logic pop_min;
		logic stale_max;
		logic stale_min;
		logic win_ok;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== sv/lwb_deque.sv =====
// ----------------------------------------------------------------------------
// lwb_deque
// Monotonic index deque held in a memory, with head and tail pointers and one
// registered read port that looks at either the head or the tail entry.
// ----------------------------------------------------------------------------
module lwb_deque
	import lwb_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int SW    = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dq_cmd_t                      cmd,
	input  logic [$clog2(DEPTH)-1:0]     wr_idx,
	input  logic [SW-1:0]                wr_val,
	output logic [$clog2(DEPTH)-1:0]     rd_idx,
	output logic [SW-1:0]                rd_val,
	output logic                         nonempty
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    head_q;
	logic [CW-1:0]    tail_q;
	logic [CW-1:0]    tail_dec;
	logic [IW-1:0]    rd_addr;
	logic [IW+SW-1:0] mem [DEPTH];
	logic [IW+SW-1:0] rd_q;

	assign tail_dec = tail_q - CW'(1);
	assign rd_addr  = cmd.sel_head ? head_q[IW-1:0] : tail_dec[IW-1:0];
	assign nonempty = tail_q > head_q;
	assign rd_idx   = rd_q[IW+SW-1:SW];
	assign rd_val   = rd_q[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.clr) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (cmd.pop) begin
				tail_q <= tail_dec;
			end else if (cmd.push) begin
				tail_q <= tail_q + CW'(1);
			end
			if (cmd.adv) begin
				head_q <= head_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q[IW-1:0]] <= {wr_idx, wr_val};
		end
		rd_q <= mem[rd_addr];
	end

endmodule

// ===== sv/lwb_datapath.sv =====
// ----------------------------------------------------------------------------
// lwb_datapath
// Sample latch, sequence counters, the max and min deques, the band check
// and the output register.
// ----------------------------------------------------------------------------
`include "longest_window_within_band_macros.svh"

module lwb_datapath
	import lwb_pkg::*;
#(
	parameter int MAX_LEN = 1024,
	parameter int SW      = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctl_cmd_t                  cmd,
	output ctl_sts_t                  sts,
	input  logic [SAMPLE_FIELD_W-1:0] s_data,
	input  logic                      s_start,
	input  logic                      cfg_we,
	input  logic [BAND_W-1:0]         cfg_wdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_DATA_W-1:0]     m_tdata,
	output logic                      m_tuser
);

	localparam int IW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	logic [BAND_W-1:0] band_q;
	logic [SW-1:0]     s_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     ws_q;
	logic [CW-1:0]     best_q;
	logic              ovf_q;
	logic              m_tvalid_q;
	logic [LEN_W-1:0]  run_out_q;
	logic [LEN_W-1:0]  best_out_q;
	logic              ovf_out_q;

	logic              seq_clr;
	dq_cmd_t           mx_cmd;
	dq_cmd_t           mn_cmd;
	logic [IW-1:0]     mx_idx;
	logic [IW-1:0]     mn_idx;
	logic [SW-1:0]     mx_val;
	logic [SW-1:0]     mn_val;
	logic              mx_ne;
	logic              mn_ne;
	logic [SW-1:0]     diff;
	logic [CW-1:0]     run;
	logic [CW-1:0]     best_next;

	assign seq_clr = cmd.take && s_start;

	assign mx_cmd = '{clr: seq_clr, sel_head: cmd.sel_head, pop: cmd.pop_max,
		push: cmd.push, adv: cmd.adv_max};
	assign mn_cmd = '{clr: seq_clr, sel_head: cmd.sel_head, pop: cmd.pop_min,
		push: cmd.push, adv: cmd.adv_min};

	lwb_deque #(.DEPTH(MAX_LEN), .SW(SW)) u_max_dq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (mx_cmd),
		.wr_idx   (count_q[IW-1:0]),
		.wr_val   (s_q),
		.rd_idx   (mx_idx),
		.rd_val   (mx_val),
		.nonempty (mx_ne)
	);

	lwb_deque #(.DEPTH(MAX_LEN), .SW(SW)) u_min_dq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (mn_cmd),
		.wr_idx   (count_q[IW-1:0]),
		.wr_val   (s_q),
		.rd_idx   (mn_idx),
		.rd_val   (mn_val),
		.nonempty (mn_ne)
	);

	assign diff      = mx_val - mn_val;
	assign run       = ovf_q ? '0 : count_q - CW'(ws_q);
	assign best_next = (run > best_q) ? run : best_q;

	assign sts.full      = count_q == CW'(MAX_LEN);
	assign sts.pop_max   = mx_ne && (mx_val <= s_q);
	assign sts.pop_min   = mn_ne && (mn_val >= s_q);
	assign sts.stale_max = mx_idx < ws_q;
	assign sts.stale_min = mn_idx < ws_q;
	assign sts.win_ok    = ((CW'(ws_q) + CW'(1)) >= count_q) ||
		(BAND_W'(diff) <= band_q);
	assign sts.out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= '0;
		end else if (cfg_we) begin
			band_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			s_q <= s_data[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ws_q    <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (seq_clr) begin
				count_q <= '0;
				ws_q    <= '0;
				best_q  <= '0;
			end else begin
				if (cmd.push) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.step_ws) begin
					ws_q <= ws_q + IW'(1);
				end
				if (cmd.load_out) begin
					best_q <= best_next;
				end
			end
			if (cmd.take) begin
				ovf_q <= 1'b0;
			end else if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			run_out_q  <= LEN_W'(run);
			best_out_q <= LEN_W'(best_next);
			ovf_out_q  <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2 * LEN_W){1'b0}}, best_out_q, run_out_q};
	assign m_tuser  = ovf_out_q;

	`LWB_ASSERT_HOLDS(a_ws_within_seq, CW'(ws_q) <= count_q, "Window start ran past the count.")
	`LWB_ASSERT_IMPLY(a_push_room, cmd.push, !sts.full, "Push into a full sequence.")
	`LWB_ASSERT_IMPLY(a_ovf_no_run, m_tvalid_q && ovf_out_q, run_out_q == '0,
		"Overflow beat carries a nonzero run.")
	`LWB_ASSERT_NEXT(a_load_shows, cmd.load_out, m_tvalid_q, "Loaded result is not offered.")

endmodule

// ===== sv/lwb_ctrl.sv =====
// ----------------------------------------------------------------------------
// lwb_ctrl
// Sequencer for one sample: tail pops on either deque or both, push, head
// refresh, window advance, overflow flag and hand-off to the output register.
// ----------------------------------------------------------------------------
module lwb_ctrl
	import lwb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output ctl_cmd_t cmd,
	input  ctl_sts_t sts
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PCMP = 7'b0000010,
		ST_PRD  = 7'b0000100,
		ST_PUSH = 7'b0001000,
		ST_HRD  = 7'b0010000,
		ST_EVAL = 7'b0100000,
		ST_WAIT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = ST_PCMP;
				end
			end
			ST_PCMP: begin
				if (sts.full) begin
					cmd.set_ovf = 1'b1;
					state_d     = ST_WAIT;
				end else if (sts.pop_max || sts.pop_min) begin
					cmd.pop_max = sts.pop_max;
					cmd.pop_min = sts.pop_min;
					state_d     = ST_PRD;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PRD: begin
				state_d = ST_PCMP;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_HRD;
			end
			ST_HRD: begin
				cmd.sel_head = 1'b1;
				state_d      = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.sel_head = 1'b1;
				if (sts.stale_max || sts.stale_min) begin
					cmd.adv_max = sts.stale_max;
					cmd.adv_min = sts.stale_min;
					state_d     = ST_HRD;
				end else if (!sts.win_ok) begin
					cmd.step_ws = 1'b1;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/longest_window_within_band.sv =====
// ----------------------------------------------------------------------------
// longest_window_within_band
// Longest run ending at each sample whose max minus min stays within a band.
// ----------------------------------------------------------------------------
// Each input beat carries one sample and a start flag; each one gives exactly
// one output beat with the run length, the best length of the sequence and
// an overflow flag. When no deque entry is dropped and the window start does
// not move, an accepted sample goes through the tail compare, push, head read
// and evaluate states to the result register, and the controller then returns
// to idle to take the next beat. Each round of tail drops, which removes one
// entry from either deque or from both, adds a tail read and a compare state,
// each refresh of stale heads adds a head read and an evaluate state, and each
// step of the window start repeats the evaluate state. Every index leaves each
// deque at most once and the window start moves no more often than samples
// arrive. A sample that meets a full sequence is flagged as overflow and goes
// through the wait state to the result register. The sequencing is set by the
// single registered read port of each deque memory, which is shared between
// tail checks and head lookups. A new beat is taken while the previous result
// still waits at the output.
// ----------------------------------------------------------------------------
module longest_window_within_band
	import lwb_pkg::*;
#(
	parameter int MAX_LEN     = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // sample
	input  logic                  s_tuser,   // start_req
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // run_length, best_length, zero fill
	output logic                  m_tuser,   // overflow
	input  logic                  cfg_we,
	input  logic [BAND_W-1:0]     cfg_wdata  // band_width
);

	localparam int SW = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	lwb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lwb_datapath #(.MAX_LEN(MAX_LEN), .SW(SW)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_data    (s_tdata[SAMPLE_FIELD_W-1:0]),
		.s_start   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== bench/longest_window_within_band_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// longest_window_within_band_test
// Self-checking bench for the in-band window length search.
// ----------------------------------------------------------------------------
// A short table of samples and band writes comes first, with the easy results
// typed in. Random sequences follow under three idle patterns. One of them
// fills a sequence to its limit and runs past it. The other result beats are
// compared with a bench-side model of the window and the best length.
// ----------------------------------------------------------------------------
module longest_window_within_band_test
	import lwb_pkg::*;
();

	localparam int SEQ_CAP        = 1024;
	localparam int RANDOM_PER_PHASE = 260;
	localparam int HOLD_CYCLES    = 400;
	localparam int STALL_LIMIT    = 20000;
	localparam int SETTLE_CYCLES  = 60;
	localparam int NUM_ROWS       = 16;

	typedef struct packed {
		logic [LEN_W-1:0] run_len;
		logic [LEN_W-1:0] best_len;
		logic             ovf;
	} window_result_t;

	typedef struct packed {
		logic             is_cfg;
		logic [31:0]      value;
		logic             start;
		logic             typed;
		logic [LEN_W-1:0] run_len;
		logic [LEN_W-1:0] best_len;
		logic             ovf;
	} stim_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_we    = 1'b0;
	logic [BAND_W-1:0]     cfg_wdata = '0;

	window_result_t pending_windows[$];
	window_result_t got_window;
	window_result_t due_window;

	logic [31:0] seq_val [0:SEQ_CAP-1];
	int          seq_len  = 0;
	int          win_lo   = 0;
	int          best_run = 0;
	logic [31:0] band     = '0;
	logic [31:0] seq_base = '0;

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit hold_req     = 1'b0;
	bit hold_done    = 1'b0;
	int hold_left    = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;

	stim_row_t directed_rows [0:NUM_ROWS-1] = '{
		'{1'b0, 32'h0000_0000, 1'b0, 1'b1, 11'd1, 11'd1, 1'b0},
		'{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 11'd1, 11'd1, 1'b0},
		'{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 11'd2, 11'd2, 1'b0},
		'{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 11'd3, 11'd3, 1'b0},
		'{1'b0, 32'h0000_0000, 1'b0, 1'b1, 11'd1, 11'd3, 1'b0},
		'{1'b0, 32'h0000_0005, 1'b1, 1'b1, 11'd1, 11'd1, 1'b0},
		'{1'b0, 32'h0000_0005, 1'b0, 1'b1, 11'd2, 11'd2, 1'b0},
		'{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
		'{1'b0, 32'h0000_0000, 1'b0, 1'b1, 11'd3, 11'd3, 1'b0},
		'{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 11'd4, 11'd4, 1'b0},
		'{1'b1, 32'h0000_000A, 1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
		'{1'b0, 32'h0000_0064, 1'b1, 1'b1, 11'd1, 11'd1, 1'b0},
		'{1'b0, 32'h0000_006E, 1'b0, 1'b1, 11'd2, 11'd2, 1'b0},
		'{1'b0, 32'h0000_006F, 1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
		'{1'b0, 32'h0000_0069, 1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
		'{1'b0, 32'h0000_0078, 1'b0, 1'b0, 11'd0, 11'd0, 1'b0}
	};

	longest_window_within_band i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// The window start only moves right, so scanning left from the newest
	// sample until the range breaks the band gives the new start.
	function automatic window_result_t predict_window(input logic [31:0] smp, input logic st);
		int             idx;
		int             j;
		logic [31:0]    hi;
		logic [31:0]    lo;
		window_result_t r;
		if (st) begin
			seq_len  = 0;
			win_lo   = 0;
			best_run = 0;
		end
		if (seq_len >= SEQ_CAP) begin
			r.run_len  = '0;
			r.best_len = best_run[LEN_W-1:0];
			r.ovf      = 1'b1;
			return r;
		end
		idx          = seq_len;
		seq_val[idx] = smp;
		seq_len      = idx + 1;
		hi           = smp;
		lo           = smp;
		j            = idx;
		while (j > win_lo) begin
			if (seq_val[j-1] > hi)
				hi = seq_val[j-1];
			if (seq_val[j-1] < lo)
				lo = seq_val[j-1];
			if (hi - lo > band)
				break;
			j--;
		end
		win_lo = j;
		if (idx - win_lo + 1 > best_run)
			best_run = idx - win_lo + 1;
		r.run_len  = LEN_W'(idx - win_lo + 1);
		r.best_len = best_run[LEN_W-1:0];
		r.ovf      = 1'b0;
		return r;
	endfunction

	task automatic offer_sample(input logic [31:0] smp, input logic st, input logic typed,
			input window_result_t typed_res);
		window_result_t r;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= st;
		do
			@(posedge clk);
		while (!s_tready);
		r = predict_window(smp, st);
		pending_windows.push_back(typed ? typed_res : r);
	endtask

	task automatic write_band(input logic [31:0] value);
		s_tvalid <= 1'b0;
		while (pending_windows.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		band = value;
	endtask

	task automatic offer_random_sample(input logic force_start, input logic no_start);
		logic [31:0] spread;
		logic [31:0] smp;
		logic        st;
		int          pick;
		st = force_start || (!no_start && $urandom_range(0, 99) < 3);
		if (st)
			seq_base = $urandom;
		spread = (band > 32'd100_000_000) ? 32'hFFFF_FFFF : band + (band >> 1) + 32'd2;
		pick   = $urandom_range(0, 99);
		if (pick < 15)
			seq_base = seq_base + $urandom_range(0, spread >> 2) - (spread >> 3);
		if (pick < 70)
			smp = (spread == 32'hFFFF_FFFF) ? $urandom : seq_base + $urandom_range(0, spread);
		else if (pick < 80)
			smp = $urandom;
		else if (pick < 90)
			smp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		else
			smp = seq_base;
		offer_sample(smp, st, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_window.run_len  = m_tdata[LEN_W-1:0];
				got_window.best_len = m_tdata[2*LEN_W-1:LEN_W];
				got_window.ovf      = m_tuser;
				if (pending_windows.size() == 0) begin
					$error("Result beat arrived with no sample outstanding.");
					mismatches++;
				end else begin
					due_window = pending_windows.pop_front();
					if (got_window.run_len !== due_window.run_len) begin
						$error("run_length: expected %0d, actual %0d",
							due_window.run_len, got_window.run_len);
						mismatches++;
					end
					if (got_window.best_len !== due_window.best_len) begin
						$error("best_length: expected %0d, actual %0d",
							due_window.best_len, got_window.best_len);
						mismatches++;
					end
					if (got_window.ovf !== due_window.ovf) begin
						$error("overflow: expected %0d, actual %0d",
							due_window.ovf, got_window.ovf);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 26;
		snk_idle_pct = 52;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_band(directed_rows[i].value);
			else
				offer_sample(directed_rows[i].value, directed_rows[i].start,
					directed_rows[i].typed, {directed_rows[i].run_len,
					directed_rows[i].best_len, directed_rows[i].ovf});
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 26;
					snk_idle_pct = 52;
					write_band(32'h0000_0000);
					hold_req = 1'b1;
				end
				1: begin
					src_idle_pct = 52;
					snk_idle_pct = 26;
					write_band($urandom);
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
					write_band($urandom_range(50, 500));
					offer_random_sample(1'b1, 1'b0);
					for (int k = 1; k < SEQ_CAP + 5; k++)
						offer_random_sample(1'b0, 1'b1);
					offer_random_sample(1'b1, 1'b0);
				end
			endcase
			for (int k = 0; k < RANDOM_PER_PHASE; k++)
				offer_random_sample(1'b0, 1'b0);
		end

		s_tvalid <= 1'b0;
		while (pending_windows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/lwb_pkg.sv
sv/lwb_deque.sv
sv/lwb_datapath.sv
sv/lwb_ctrl.sv
sv/longest_window_within_band.sv
bench/longest_window_within_band_test.sv
